>>> src/crc8fc_pkg.sv
package crc8fc_pkg;

    // default frame layout
    localparam int FRAME_BYTES_DEF   = 6;
    localparam int PAYLOAD_BYTES_DEF = 2;

    // crc-8 definition: poly x^8 + x^2 + x + 1, msb first, no reflection
    localparam logic [7:0] CRC_POLY   = 8'h07;
    localparam logic [7:0] CRC_TOP    = 8'h80;
    localparam logic [7:0] CRC_INIT   = 8'h00;
    localparam logic [7:0] SYNC_RESET = 8'hAA;

    // frame status codes
    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_BAD_SYNC = 2'd1;
    localparam logic [1:0] STATUS_BAD_CRC  = 2'd2;

    // one finished frame report
    typedef struct packed {
        logic [1:0]  frame_status;
        logic [7:0]  command;
        logic [15:0] payload;
        logic [7:0]  received_crc;
    } frame_result_t;

    // byte-wise crc update, eight shift steps unrolled
    function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] data);
        logic [7:0] v;
        v = crc ^ data;
        for (int k = 0; k < 8; k++) begin
            if ((v & CRC_TOP) != 8'h00)
            begin
                v = {v[6:0], 1'b0} ^ CRC_POLY;
            end
            else
            begin
                v = {v[6:0], 1'b0};
            end
        end
        return v;
    endfunction

endpackage

>>> src/crc8_frame_checker.sv
// channel   | handshake             | payload
// ----------+-----------------------+--------------------------------------------
// input     | in_valid / in_ready   | rx_byte
// result    | out_valid / out_ready | frame_status, command, payload, received_crc
// config    | cfg_we (no wait)      | cfg_wdata (sync byte)
//
// one byte per cycle; the crc-8 update is a single unrolled byte step
// a report appears in the cycle after the spare byte of a frame is accepted
// reset clears the frame counter and crc and restores sync byte 0xAA
// only the last byte of a frame stalls, and only while a report is held
module crc8_frame_checker
    import crc8fc_pkg::*;
#(
    parameter int FRAME_BYTES   = FRAME_BYTES_DEF,
    parameter int PAYLOAD_BYTES = PAYLOAD_BYTES_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [7:0]  cfg_wdata,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  rx_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  frame_status,
    output logic [7:0]  command,
    output logic [15:0] payload,
    output logic [7:0]  received_crc
);

    logic          at_last;
    logic          slot_free;
    logic          byte_fire;
    logic          result_fire;
    frame_result_t result;
    frame_result_t out_data;

    // non-final bytes are always taken
    assign in_ready  = !at_last || slot_free;
    assign byte_fire = in_valid && in_ready;

    crc8fc_frame #(
        .FRAME_BYTES   (FRAME_BYTES),
        .PAYLOAD_BYTES (PAYLOAD_BYTES)
    ) u_frame (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .byte_fire   (byte_fire),
        .rx_byte     (rx_byte),
        .at_last     (at_last),
        .result_fire (result_fire),
        .result      (result)
    );

    crc8fc_out u_out (
        .clk         (clk),
        .rst_n       (rst_n),
        .result_fire (result_fire),
        .result      (result),
        .slot_free   (slot_free),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_data    (out_data)
    );

    assign frame_status = out_data.frame_status;
    assign command      = out_data.command;
    assign payload      = out_data.payload;
    assign received_crc = out_data.received_crc;

`ifndef SYNTH
    // a new report never lands on one that is still waiting
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        !(result_fire && out_valid && !out_ready))
        else $error("report overwritten before transaction");
`endif

endmodule

>>> src/crc8fc_frame.sv
module crc8fc_frame
    import crc8fc_pkg::*;
#(
    parameter int FRAME_BYTES   = FRAME_BYTES_DEF,
    parameter int PAYLOAD_BYTES = PAYLOAD_BYTES_DEF
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cfg_we,
    input  logic [7:0]    cfg_wdata,
    input  logic          byte_fire,
    input  logic [7:0]    rx_byte,
    output logic          at_last,
    output logic          result_fire,
    output frame_result_t result
);

    localparam int POS_W     = $clog2(FRAME_BYTES);
    localparam int CRC_POS   = FRAME_BYTES - 2;
    localparam int LAST_POS  = FRAME_BYTES - 1;
    localparam int CAP_BYTES = (PAYLOAD_BYTES < 2) ? PAYLOAD_BYTES : 2;

    logic [7:0]       sync_reg;
    logic [POS_W-1:0] pos_reg,      pos_next;
    logic [7:0]       crc_reg,      crc_next;
    logic             sync_ok_reg,  sync_ok_next;
    logic [7:0]       cmd_reg,      cmd_next;
    logic [15:0]      payload_reg,  payload_next;
    logic [7:0]       chk_reg,      chk_next;
    logic [7:0]       pos_ext;
    logic [1:0]       status;

    assign pos_ext = 8'(pos_reg);
    assign at_last = (pos_ext == 8'(LAST_POS));

    // sync byte register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sync_reg <= SYNC_RESET;
        end
        else if (cfg_we)
        begin
            sync_reg <= cfg_wdata;
        end
    end

    // per-byte frame update
    always_comb
    begin
        pos_next     = pos_reg;
        crc_next     = crc_reg;
        sync_ok_next = sync_ok_reg;
        cmd_next     = cmd_reg;
        payload_next = payload_reg;
        chk_next     = chk_reg;
        if (byte_fire)
        begin
            if (at_last)
            begin
                pos_next     = '0;
                crc_next     = CRC_INIT;
                sync_ok_next = 1'b0;
                cmd_next     = 8'h00;
                payload_next = 16'h0000;
                chk_next     = 8'h00;
            end
            else
            begin
                pos_next = pos_reg + 1'b1;
                if (pos_ext < 8'(CRC_POS))
                begin
                    crc_next = crc8_update(crc_reg, rx_byte);
                    if (pos_ext == 8'd0)
                    begin
                        sync_ok_next = (rx_byte == sync_reg);
                    end
                    else if (pos_ext == 8'd1)
                    begin
                        cmd_next = rx_byte;
                    end
                    else if (pos_ext < 8'(2 + CAP_BYTES))
                    begin
                        // payload byte, first one in the low half
                        if (pos_ext == 8'd2)
                        begin
                            payload_next[7:0] = payload_reg[7:0] | rx_byte;
                        end
                        else
                        begin
                            payload_next[15:8] = payload_reg[15:8] | rx_byte;
                        end
                    end
                end
                else if (pos_ext == 8'(CRC_POS))
                begin
                    chk_next = rx_byte;
                end
            end
        end
    end

    // frame state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg     <= '0;
            crc_reg     <= CRC_INIT;
            sync_ok_reg <= 1'b0;
            cmd_reg     <= 8'h00;
            payload_reg <= 16'h0000;
            chk_reg     <= 8'h00;
        end
        else
        begin
            pos_reg     <= pos_next;
            crc_reg     <= crc_next;
            sync_ok_reg <= sync_ok_next;
            cmd_reg     <= cmd_next;
            payload_reg <= payload_next;
            chk_reg     <= chk_next;
        end
    end

    // status of the finished frame, bad sync wins over bad crc
    always_comb
    begin
        if (!sync_ok_reg)
        begin
            status = STATUS_BAD_SYNC;
        end
        else if (chk_reg != crc_reg)
        begin
            status = STATUS_BAD_CRC;
        end
        else
        begin
            status = STATUS_OK;
        end
    end

    // report built from the held fields when the spare byte arrives
    assign result_fire         = byte_fire && at_last;
    assign result.frame_status = status;
    assign result.command      = cmd_reg;
    assign result.payload      = payload_reg;
    assign result.received_crc = chk_reg;

`ifndef SYNTH
    // position never runs past the spare byte
    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        pos_ext <= 8'(LAST_POS))
        else $error("byte position beyond frame end");

    // counter restarts after a finished frame
    a_pos_wrap: assert property (@(posedge clk) disable iff (!rst_n)
        result_fire |=> (pos_reg == '0) && (crc_reg == CRC_INIT) && !sync_ok_reg)
        else $error("frame state not cleared after report");
`endif

endmodule

>>> src/crc8fc_out.sv
module crc8fc_out
    import crc8fc_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          result_fire,
    input  frame_result_t result,
    output logic          slot_free,
    output logic          out_valid,
    input  logic          out_ready,
    output frame_result_t out_data
);

    logic          valid_reg, valid_next;
    frame_result_t data_reg;

    // slot can take a new report when empty or being drained
    assign slot_free = !valid_reg || out_ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (result_fire)
        begin
            valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // report payload, no reset needed
    always_ff @(posedge clk)
    begin
        if (result_fire)
        begin
            data_reg <= result;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

`ifndef SYNTH
    // reserved status code never leaves the block
    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg |-> (data_reg.frame_status != 2'd3))
        else $error("reserved frame status reported");
`endif

endmodule
